// ===== rtl/core/c3pf_pkg.sv =====
// Shared types, widths and constants of the 3x3 pixel convolution filter.
// Used by the channel interfaces and by every filter module except the generic RAM.
package c3pf_pkg;

	localparam int PIXEL_W        = 8;
	localparam int COLUMN_W       = 10;
	localparam int ROW_W          = 12;
	localparam int MASK_W         = 63;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int COEF_W         = 7;
	localparam int TAPS           = 9;

	localparam int C3PF_MAX_WIDTH  = 1024;
	localparam int C3PF_MAX_HEIGHT = 4096;

	// output queue depth, must be a power of two
	localparam int OUT_DEPTH = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MASK_W;

	localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = FRAME_WIDTH_W'(1024);
	localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = FRAME_HEIGHT_W'(4096);
	localparam logic [PIXEL_W-1:0]        PIXEL_MAX    = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_CLAMP = 1'b0,
		MODE_ABS   = 1'b1
	} mode_t;

	typedef logic [TAPS-1:0][PIXEL_W-1:0] window_t;

	// position and flags that travel alongside a pixel through the pipeline
	typedef struct packed {
		logic                emit;
		logic [COLUMN_W-1:0] col;
		logic [ROW_W-1:0]    row;
		logic                fend;
	} tag_t;

	typedef struct packed {
		logic [PIXEL_W-1:0]  filtered;
		logic [COLUMN_W-1:0] center_column;
		logic [ROW_W-1:0]    center_row;
		logic                frame_end;
	} out_word_t;

	// fixed north mask, columns x-1, x, x+1
	localparam logic signed [7:0] NORTH_MASK [TAPS] = '{
		8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd2, 8'sd1, -8'sd1, -8'sd1, -8'sd1
	};

	function automatic logic signed [7:0] mask_coef(input logic [MASK_W-1:0] m,
			input int unsigned k);
		logic [COEF_W-1:0] f;
		f = m[COEF_W*k +: COEF_W];
		return {f[COEF_W-1], f};
	endfunction

endpackage

// ===== rtl/core/c3pf_in_if.sv =====
// Pixel input channel of the 3x3 convolution filter.
// Depends on c3pf_pkg for the field widths.
interface c3pf_in_if import c3pf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink (input valid, pixel, frame_start, output ready);
endinterface

// ===== rtl/core/c3pf_out_if.sv =====
// Result channel of the 3x3 convolution filter.
// Depends on c3pf_pkg for the field widths.
interface c3pf_out_if import c3pf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PIXEL_W-1:0]  filtered;
	logic [COLUMN_W-1:0] center_column;
	logic [ROW_W-1:0]    center_row;
	logic                frame_end;

	modport source (output valid, filtered, center_column, center_row, frame_end,
		input ready);
	modport sink (input valid, filtered, center_column, center_row, frame_end,
		output ready);
endinterface

// ===== rtl/core/c3pf_ram.sv =====
// Generic simple dual-port RAM with registered read, read-before-write.
// No package dependencies.
module c3pf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== rtl/core/c3pf_mac.sv =====
// Nine-tap multiply stage and sum/clamp logic of the 3x3 convolution filter.
// Depends on c3pf_pkg.
module c3pf_mac import c3pf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  window_t             win,
	input  mode_t               mode,
	input  logic [MASK_W-1:0]   mask,
	input  logic                tag_valid,
	input  tag_t                tag,
	output logic                busy,
	output logic                push,
	output out_word_t           word
);

	localparam int PROD_W = 17;
	localparam int SUM_W  = 21;

	logic signed [PROD_W-1:0] prod_d  [TAPS];
	logic signed [PROD_W-1:0] prod_s3 [TAPS];
	logic                     valid_s3;
	tag_t                     tag_s3;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  mag;
	logic [PIXEL_W-1:0]       value;

	always_comb begin
		logic signed [7:0] coef;
		for (int k = 0; k < TAPS; k++) begin
			coef = (mode == MODE_ABS) ? NORTH_MASK[k] : mask_coef(mask, k);
			prod_d[k] = coef * $signed({1'b0, win[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= tag_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag;
		for (int k = 0; k < TAPS; k++) begin
			prod_s3[k] <= prod_d[k];
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			sum = sum + SUM_W'(prod_s3[k]);
		end
		mag = (mode == MODE_ABS && sum < 0) ? -sum : sum;
		if (mag < 0) begin
			value = '0;
		end else if (mag > SUM_W'(PIXEL_MAX)) begin
			value = PIXEL_MAX;
		end else begin
			value = mag[PIXEL_W-1:0];
		end
	end

	assign busy = valid_s3;
	assign push = valid_s3 && tag_s3.emit;
	assign word = '{filtered: value, center_column: tag_s3.col,
		center_row: tag_s3.row, frame_end: tag_s3.fend};

endmodule

// ===== rtl/core/c3pf_out_fifo.sv =====
// Small result queue that decouples the filter pipeline from the consumer.
// Depends on c3pf_pkg; the depth comes from OUT_DEPTH.
module c3pf_out_fifo import c3pf_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  out_word_t                      push_word,
	input  logic                           pop,
	output logic                           not_empty,
	output out_word_t                      head,
	output logic [$clog2(OUT_DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH+1);

	out_word_t          mem [OUT_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];
	assign count     = count_q;

endmodule

// ===== rtl/core/conv3x3_pixel_filter_unit.sv =====
// 3x3 convolution filter over one 8-bit plane in raster order: top level.
// Depends on c3pf_pkg, c3pf_in_if, c3pf_out_if, c3pf_ram, c3pf_mac, c3pf_out_fifo.
//
// Accepts one pixel word per clock while ready is high and returns one result
// word per interior window center after the RAM-read, window and product
// registers. The two rows above the current pixel live in one MAX_WIDTH x 16
// RAM (middle row in the upper byte, upper row in the lower byte), read when
// the pixel is accepted and written back in the next cycle; a back-to-back
// revisit of the same column is forwarded around the RAM. Results wait in an
// eight-word queue; ready drops only when that queue plus the words still in
// the three pipeline stages could fill it, so with a consumer that takes a
// word every clock the rate stays at one pixel per clock. The RAM needs no
// clearing after reset. Border pixels produce no result.
module conv3x3_pixel_filter_unit import c3pf_pkg::*; #(
	parameter int MAX_WIDTH  = C3PF_MAX_WIDTH,
	parameter int MAX_HEIGHT = C3PF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	c3pf_in_if.sink               in_ch,
	c3pf_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WL    = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;
	localparam int HL    = (RW + 1 > FRAME_HEIGHT_W) ? RW + 1 : FRAME_HEIGHT_W;
	localparam int LW    = 2 * PIXEL_W;
	localparam int CNT_W = $clog2(OUT_DEPTH+1);

	// configuration
	logic [MASK_W-1:0]         mask_q;
	logic [FRAME_WIDTH_W-1:0]  width_q;
	logic [FRAME_HEIGHT_W-1:0] height_q;
	mode_t                     mode_q;

	logic [WL-1:0] w_eff;
	logic [HL-1:0] h_eff;

	// position counters and accept-side logic
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [CW-1:0] cm1;
	logic [RW-1:0] rm1;
	logic [WL-1:0] c_inc;
	logic [HL-1:0] r_inc;
	logic          accept;
	tag_t          tag_d;

	// stage 1: RAM read in flight
	logic               valid_s1;
	logic [PIXEL_W-1:0] px_s1;
	logic [CW-1:0]      c_s1;
	tag_t               tag_s1;
	logic               byp_s1;
	logic [LW-1:0]      byp_word_s1;

	logic [LW-1:0]      ram_rdata;
	logic [LW-1:0]      line_word;
	logic [LW-1:0]      ram_wdata;

	// stage 2: window updated
	window_t win_q;
	logic    valid_s2;
	tag_t    tag_s2;

	logic                   mac_busy;
	logic                   fifo_push;
	out_word_t              fifo_in;
	out_word_t              fifo_head;
	logic                   fifo_not_empty;
	logic [CNT_W-1:0]       fifo_count;
	logic                   pop;
	logic [CNT_W:0]         credit_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			mode_q   <= MODE_CLAMP;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MASK:   mask_q   <= cfg_wdata[MASK_W-1:0];
				REG_WIDTH:  width_q  <= cfg_wdata[FRAME_WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[FRAME_HEIGHT_W-1:0];
				REG_MODE:   mode_q   <= mode_t'(cfg_wdata[0]);
				default:    mask_q   <= mask_q;
			endcase
		end
	end

	// out-of-range sizes snap to the nearest legal size
	always_comb begin
		if (WL'(width_q) < WL'(3)) begin
			w_eff = WL'(3);
		end else if (WL'(width_q) > WL'(MAX_WIDTH)) begin
			w_eff = WL'(MAX_WIDTH);
		end else begin
			w_eff = WL'(width_q);
		end
		if (HL'(height_q) < HL'(3)) begin
			h_eff = HL'(3);
		end else if (HL'(height_q) > HL'(MAX_HEIGHT)) begin
			h_eff = HL'(MAX_HEIGHT);
		end else begin
			h_eff = HL'(height_q);
		end
	end

	assign credit_used  = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(valid_s1)
		+ (CNT_W+1)'(valid_s2) + (CNT_W+1)'(mac_busy);
	assign in_ch.ready  = (credit_used < (CNT_W+1)'(OUT_DEPTH));
	assign accept       = in_ch.valid && in_ch.ready;

	assign c0    = in_ch.frame_start ? '0 : col_q;
	assign r0    = in_ch.frame_start ? '0 : row_q;
	assign c_inc = WL'(c0) + WL'(1);
	assign r_inc = HL'(r0) + HL'(1);
	assign cm1   = c0 - CW'(1);
	assign rm1   = r0 - RW'(1);

	always_comb begin
		tag_d.emit = (c0 >= CW'(2)) && (r0 >= RW'(2))
			&& (WL'(c0) < w_eff) && (HL'(r0) < h_eff);
		tag_d.col  = COLUMN_W'(cm1);
		tag_d.row  = ROW_W'(rm1);
		tag_d.fend = (c_inc == w_eff) && (r_inc == h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
				end else begin
					col_q <= c_inc[CW-1:0];
					row_q <= (HL'(r0) >= h_eff) ? '0 : r0;
				end
			end
		end
	end

	// forward the pending write when the new read hits the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= in_ch.pixel;
			c_s1        <= c0;
			tag_s1      <= tag_d;
			byp_s1      <= valid_s1 && (c_s1 == c0);
			byp_word_s1 <= ram_wdata;
		end
	end

	assign line_word = byp_s1 ? byp_word_s1 : ram_rdata;
	// middle row moves up, new pixel becomes the middle row
	assign ram_wdata = {px_s1, line_word[LW-1:PIXEL_W]};

	c3pf_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (c_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (c0),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int k = 0; k < TAPS - 3; k++) begin
				win_q[k] <= win_q[k+3];
			end
			win_q[6] <= line_word[PIXEL_W-1:0];
			win_q[7] <= line_word[LW-1:PIXEL_W];
			win_q[8] <= px_s1;
		end
		tag_s2 <= tag_s1;
	end

	c3pf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.mode      (mode_q),
		.mask      (mask_q),
		.tag_valid (valid_s2),
		.tag       (tag_s2),
		.busy      (mac_busy),
		.push      (fifo_push),
		.word      (fifo_in)
	);

	assign pop = out_ch.valid && out_ch.ready;

	c3pf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_word (fifo_in),
		.pop       (pop),
		.not_empty (fifo_not_empty),
		.head      (fifo_head),
		.count     (fifo_count)
	);

	assign out_ch.valid         = fifo_not_empty;
	assign out_ch.filtered      = fifo_head.filtered;
	assign out_ch.center_column = fifo_head.center_column;
	assign out_ch.center_row    = fifo_head.center_row;
	assign out_ch.frame_end     = fifo_head.frame_end;

`ifndef SYNTHESIS
	// the queue never takes a word while full unless a word leaves in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push && !pop) |-> (fifo_count < CNT_W'(OUT_DEPTH)))
		else $error("result queue overflow");

	// queued plus in-flight words never exceed the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= (CNT_W+1)'(OUT_DEPTH))
		else $error("credit count exceeds queue depth");

	// forwarding happens only right behind an accepted word
	a_bypass_source: assert property (@(posedge clk) disable iff (!arst_n)
		accept ##1 (valid_s1 && byp_s1) |-> $past(valid_s1, 1))
		else $error("line forwarding without a pending write");
`endif

endmodule
